// ===== rtl/hidkbd_pkg.sv =====
package hidkbd_pkg;

    localparam int FIFO_DEPTH_DEF = 16;

    // input opcodes, plus an internal code for work that yields no event
    localparam logic [2:0] OP_REPORT  = 3'd0;
    localparam logic [2:0] OP_POP     = 3'd1;
    localparam logic [2:0] OP_FLUSH   = 3'd2;
    localparam logic [2:0] OP_MOUNT   = 3'd3;
    localparam logic [2:0] OP_UNMOUNT = 3'd4;
    localparam logic [2:0] OP_IGNORE  = 3'd5;

    localparam logic [2:0] EV_NONE  = 3'd0;
    localparam logic [2:0] EV_DOWN  = 3'd1;
    localparam logic [2:0] EV_UP    = 3'd2;
    localparam logic [2:0] EV_CHAR  = 3'd3;
    localparam logic [2:0] EV_EMPTY = 3'd4;

    localparam logic [0:0] REG_LAYOUT_JIS = 1'd0;
    localparam logic [0:0] REG_CLEAR_UNMT = 1'd1;

    localparam logic [7:0] KEY_CAPS     = 8'h39;
    localparam logic [7:0] KEY_ENTER    = 8'h28;
    localparam logic [7:0] KEY_BKSP     = 8'h2A;
    localparam logic [7:0] KEY_TAB      = 8'h2B;
    localparam logic [7:0] LETTER_FIRST = 8'h04;
    localparam logic [7:0] LETTER_LAST  = 8'h1D;
    localparam logic [7:0] SYM_FIRST    = 8'h1E;
    localparam logic [7:0] SYM_LAST     = 8'h38;
    localparam logic [7:0] SHIFT_MASK   = 8'h22;
    localparam logic [7:0] MIN_REPORT   = 8'd8;

    // rows: US plain, US shifted, JIS plain, JIS shifted
    localparam logic [6:0] SYM_MAP [0:3][0:26] = '{
        '{7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38, 7'h39, 7'h30,
          7'h00, 7'h00, 7'h00, 7'h00, 7'h20, 7'h2D, 7'h3D, 7'h5B, 7'h5D, 7'h5C,
          7'h00, 7'h3B, 7'h27, 7'h60, 7'h2C, 7'h2E, 7'h2F},
        '{7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A, 7'h28, 7'h29,
          7'h00, 7'h00, 7'h00, 7'h00, 7'h20, 7'h5F, 7'h2B, 7'h7B, 7'h7D, 7'h7C,
          7'h00, 7'h3A, 7'h22, 7'h7E, 7'h3C, 7'h3E, 7'h3F},
        '{7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38, 7'h39, 7'h30,
          7'h00, 7'h00, 7'h00, 7'h00, 7'h20, 7'h2D, 7'h5E, 7'h40, 7'h5B, 7'h5D,
          7'h5C, 7'h3B, 7'h3A, 7'h00, 7'h2C, 7'h2E, 7'h2F},
        '{7'h21, 7'h22, 7'h23, 7'h24, 7'h25, 7'h26, 7'h27, 7'h28, 7'h29, 7'h00,
          7'h00, 7'h00, 7'h00, 7'h00, 7'h20, 7'h3D, 7'h7E, 7'h60, 7'h7B, 7'h7D,
          7'h5F, 7'h2B, 7'h2A, 7'h00, 7'h3C, 7'h3E, 7'h3F}
    };

    typedef struct packed {
        logic [2:0]      op;
        logic [7:0]      mods;
        logic [5:0][7:0] keys;
        logic [5:0][7:0] old_keys;
        logic [7:0]      mod_mask;
        logic [5:0]      down_mask;
        logic [5:0]      up_mask;
    } cmd_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] key;
        logic [7:0] mods;
        logic [6:0] ch;
        logic       caps;
        logic       last;
    } res_t;

    function automatic logic [6:0] to_ascii(logic [7:0] key, logic [7:0] mods,
                                            logic caps, logic jis);
        logic       sh;
        logic [6:0] c;
        logic [7:0] off;
        sh  = (mods & SHIFT_MASK) != 8'h00;
        c   = 7'h00;
        off = 8'h00;
        if (key == KEY_ENTER)
        begin
            c = 7'h0A;
        end
        else if (key == KEY_BKSP)
        begin
            c = 7'h08;
        end
        else if (key == KEY_TAB)
        begin
            c = 7'h09;
        end
        else if (key >= LETTER_FIRST && key <= LETTER_LAST)
        begin
            off = key - LETTER_FIRST;
            c   = ((sh ^ caps) ? 7'h41 : 7'h61) + off[6:0];
        end
        else if (key >= SYM_FIRST && key <= SYM_LAST)
        begin
            off = key - SYM_FIRST;
            c   = SYM_MAP[{jis, sh}][off[4:0]];
        end
        return c;
    endfunction

endpackage

// ===== rtl/hidkbd_front.sv =====
module hidkbd_front
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    output logic                   full,
    input  logic [2:0]             opcode,
    input  logic [6:0]             report_len,
    input  logic [7:0]             modifier_bits,
    input  logic [5:0][7:0]        keys_in,
    output logic                   cmd_valid,
    output hidkbd_pkg::cmd_t       cmd_out,
    input  logic                   cmd_pop
);

    logic [7:0]      prev_mods_reg, prev_mods_next;
    logic [5:0][7:0] old_keys_reg, old_keys_next;
    logic            prev_valid_reg, prev_valid_next;

    hidkbd_pkg::cmd_t q_reg [2];
    logic             wr_ptr_reg, rd_ptr_reg;
    logic [1:0]       cnt_reg;

    hidkbd_pkg::cmd_t cmd_new;
    logic             accept;
    logic [5:0]       in_prev, prev_in;

    assign full      = (cnt_reg == 2'd2);
    assign accept    = push && !full;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd_out   = q_reg[rd_ptr_reg];

    // classify the request against the last report seen
    always_comb
    begin
        for (int i = 0; i < 6; i++)
        begin
            in_prev[i] = 1'b0;
            prev_in[i] = 1'b0;
            for (int j = 0; j < 6; j++)
            begin
                if (keys_in[i] == old_keys_reg[j])
                    in_prev[i] = 1'b1;
                if (old_keys_reg[i] == keys_in[j])
                    prev_in[i] = 1'b1;
            end
        end
        cmd_new          = '0;
        cmd_new.op       = opcode;
        cmd_new.mods     = modifier_bits;
        cmd_new.keys     = keys_in;
        cmd_new.old_keys = old_keys_reg;
        prev_mods_next   = prev_mods_reg;
        old_keys_next    = old_keys_reg;
        prev_valid_next  = prev_valid_reg;
        unique case (opcode) inside
            hidkbd_pkg::OP_REPORT:
            begin
                if ({1'b0, report_len} < hidkbd_pkg::MIN_REPORT)
                begin
                    cmd_new.op = hidkbd_pkg::OP_IGNORE;
                end
                else
                begin
                    for (int i = 0; i < 6; i++)
                    begin
                        cmd_new.down_mask[i] = (keys_in[i] != 8'h00) &&
                                               !(prev_valid_reg && in_prev[i]);
                        cmd_new.up_mask[i]   = prev_valid_reg &&
                                               (old_keys_reg[i] != 8'h00) && !prev_in[i];
                    end
                    cmd_new.mod_mask = prev_valid_reg ? (prev_mods_reg ^ modifier_bits)
                                                      : modifier_bits;
                    prev_mods_next  = modifier_bits;
                    old_keys_next   = keys_in;
                    prev_valid_next = 1'b1;
                end
            end
            hidkbd_pkg::OP_POP, hidkbd_pkg::OP_FLUSH:
            begin
            end
            hidkbd_pkg::OP_MOUNT:
            begin
                prev_valid_next = 1'b0;
            end
            hidkbd_pkg::OP_UNMOUNT:
            begin
                prev_mods_next  = 8'h00;
                old_keys_next   = '0;
                prev_valid_next = 1'b0;
            end
            default:
            begin
                cmd_new.op = hidkbd_pkg::OP_IGNORE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_mods_reg  <= 8'h00;
            old_keys_reg   <= '0;
            prev_valid_reg <= 1'b0;
            wr_ptr_reg     <= 1'b0;
            rd_ptr_reg     <= 1'b0;
            cnt_reg        <= 2'd0;
        end
        else
        begin
            if (accept)
            begin
                prev_mods_reg  <= prev_mods_next;
                old_keys_reg   <= old_keys_next;
                prev_valid_reg <= prev_valid_next;
                wr_ptr_reg     <= !wr_ptr_reg;
            end
            if (cmd_pop)
                rd_ptr_reg <= !rd_ptr_reg;
            cnt_reg <= cnt_reg + {1'b0, accept} - {1'b0, cmd_pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            q_reg[wr_ptr_reg] <= cmd_new;
    end

endmodule

// ===== rtl/hidkbd_back.sv =====
module hidkbd_back
#(
    parameter int FIFO_DEPTH = hidkbd_pkg::FIFO_DEPTH_DEF,
    parameter int PTR_W      = $clog2(FIFO_DEPTH),
    parameter int CNT_W      = $clog2(FIFO_DEPTH + 1)
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 layout_jis,
    input  logic                 clear_on_unmount,
    input  logic                 cmd_valid,
    input  hidkbd_pkg::cmd_t     cmd_in,
    output logic                 cmd_pop,
    output logic                 empty,
    input  logic                 pop,
    output hidkbd_pkg::res_t     res_out,
    output logic [CNT_W-1:0]     res_queued
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CHAR = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;
    localparam logic [1:0] ST_POP  = 2'd3;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FIFO_DEPTH);

    logic [1:0]        state_reg, state_next;
    hidkbd_pkg::cmd_t  cmd_reg, cmd_next;
    logic [19:0]       pend_reg, pend_next;
    logic [5:0]        cmask_reg, cmask_next;
    logic              caps_reg, caps_next;
    logic [PTR_W-1:0]  wp_reg, wp_next, rp_reg, rp_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    logic [6:0]        mem [FIFO_DEPTH];
    logic [6:0]        rdata_reg;
    logic              mem_we, mem_re;
    logic [6:0]        wdata;

    hidkbd_pkg::res_t  oq_reg [2];
    logic [CNT_W-1:0]  oq_q_reg [2];
    logic              oq_wp_reg, oq_rp_reg;
    logic [1:0]        oq_cnt_reg;
    logic              push_en, can_out, out_pop;
    hidkbd_pkg::res_t  push_ent;

    logic [19:0]       ev_oh;
    logic [5:0]        ch_oh;
    logic [7:0]        ch_key, ev_key;
    logic [6:0]        ch_val;

    assign can_out    = (oq_cnt_reg != 2'd2);
    assign empty      = (oq_cnt_reg == 2'd0);
    assign out_pop    = pop && !empty;
    assign res_out    = oq_reg[oq_rp_reg];
    assign res_queued = oq_q_reg[oq_rp_reg];

    always_comb
    begin
        ev_oh  = pend_reg & (~pend_reg + 20'd1);
        ch_oh  = cmask_reg & (~cmask_reg + 6'd1);
        ch_key = 8'h00;
        ev_key = 8'h00;
        for (int i = 0; i < 6; i++)
        begin
            if (ch_oh[i])
                ch_key = cmd_reg.keys[i];
            if (ev_oh[8 + i])
                ev_key = cmd_reg.keys[i];
            if (ev_oh[14 + i])
                ev_key = cmd_reg.old_keys[i];
        end
        ch_val = hidkbd_pkg::to_ascii(ch_key, cmd_reg.mods, caps_reg, layout_jis);
    end

    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        pend_next  = pend_reg;
        cmask_next = cmask_reg;
        caps_next  = caps_reg;
        wp_next    = wp_reg;
        rp_next    = rp_reg;
        cnt_next   = cnt_reg;
        cmd_pop    = 1'b0;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        wdata      = ch_val;
        push_en    = 1'b0;
        push_ent   = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid && can_out)
                begin
                    cmd_pop  = 1'b1;
                    cmd_next = cmd_in;
                    push_ent.kind = hidkbd_pkg::EV_NONE;
                    push_ent.last = 1'b1;
                    case (cmd_in.op)
                        hidkbd_pkg::OP_REPORT:
                        begin
                            pend_next  = {cmd_in.up_mask, cmd_in.down_mask, cmd_in.mod_mask};
                            cmask_next = cmd_in.down_mask;
                            state_next = (cmd_in.down_mask != 6'd0) ? ST_CHAR : ST_EMIT;
                        end
                        hidkbd_pkg::OP_POP:
                        begin
                            if (cnt_reg == '0)
                            begin
                                push_en       = 1'b1;
                                push_ent.kind = hidkbd_pkg::EV_EMPTY;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                rp_next    = (rp_reg == PTR_LAST) ? '0 : rp_reg + 1'b1;
                                cnt_next   = cnt_reg - 1'b1;
                                state_next = ST_POP;
                            end
                        end
                        hidkbd_pkg::OP_FLUSH:
                        begin
                            wp_next  = '0;
                            rp_next  = '0;
                            cnt_next = '0;
                            push_en  = 1'b1;
                        end
                        hidkbd_pkg::OP_UNMOUNT:
                        begin
                            if (clear_on_unmount)
                            begin
                                wp_next   = '0;
                                rp_next   = '0;
                                cnt_next  = '0;
                                caps_next = 1'b0;
                            end
                            push_en = 1'b1;
                        end
                        default:
                        begin
                            push_en = 1'b1;
                        end
                    endcase
                end
            end
            ST_CHAR:
            begin
                // one newly pressed key per cycle: toggle caps or queue its character
                if (ch_key == hidkbd_pkg::KEY_CAPS)
                begin
                    caps_next = !caps_reg;
                end
                else if (ch_val != 7'h00 && cnt_reg < CNT_FULL)
                begin
                    mem_we   = 1'b1;
                    wp_next  = (wp_reg == PTR_LAST) ? '0 : wp_reg + 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                end
                cmask_next = cmask_reg & ~ch_oh;
                if (cmask_next == 6'd0)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (can_out)
                begin
                    push_en       = 1'b1;
                    pend_next     = pend_reg & ~ev_oh;
                    push_ent.last = (pend_next == 20'd0);
                    if (pend_reg == 20'd0)
                    begin
                        push_ent.kind = hidkbd_pkg::EV_NONE;
                    end
                    else
                    begin
                        push_ent.key  = ev_key;
                        push_ent.mods = cmd_reg.mods;
                        push_ent.kind = ((|(ev_oh[7:0] & cmd_reg.mods)) || (|ev_oh[13:8]))
                                        ? hidkbd_pkg::EV_DOWN : hidkbd_pkg::EV_UP;
                    end
                    if (push_ent.last)
                        state_next = ST_IDLE;
                end
            end
            ST_POP:
            begin
                if (can_out)
                begin
                    push_en       = 1'b1;
                    push_ent.kind = hidkbd_pkg::EV_CHAR;
                    push_ent.ch   = rdata_reg;
                    push_ent.last = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        push_ent.caps = caps_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            pend_reg   <= '0;
            cmask_reg  <= '0;
            caps_reg   <= 1'b0;
            wp_reg     <= '0;
            rp_reg     <= '0;
            cnt_reg    <= '0;
            oq_wp_reg  <= 1'b0;
            oq_rp_reg  <= 1'b0;
            oq_cnt_reg <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            cmask_reg <= cmask_next;
            caps_reg  <= caps_next;
            wp_reg    <= wp_next;
            rp_reg    <= rp_next;
            cnt_reg   <= cnt_next;
            if (push_en)
                oq_wp_reg <= !oq_wp_reg;
            if (out_pop)
                oq_rp_reg <= !oq_rp_reg;
            oq_cnt_reg <= oq_cnt_reg + {1'b0, push_en} - {1'b0, out_pop};
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        if (push_en)
        begin
            oq_reg[oq_wp_reg]   <= push_ent;
            oq_q_reg[oq_wp_reg] <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[wp_reg] <= wdata;
        if (mem_re)
            rdata_reg <= mem[rp_reg];
    end

endmodule

// ===== rtl/hid_boot_keyboard_event_decoder.sv =====
// Requests are classified in hidkbd_front and wait in its two-entry queue, so new requests
// are taken while the event sequencer works; the sequencer handles one request at a time,
// a report stepping through its new keys and then up to 20 events, and stalls while
// its two-entry result queue is full.
// Reset: rst_n clears report history, caps lock, character queue, request queue and
// result queue; layout_jis resets to 0 and clear_on_unmount to 1.
module hid_boot_keyboard_event_decoder
#(
    parameter int FIFO_DEPTH = hidkbd_pkg::FIFO_DEPTH_DEF,
    parameter int CNT_W      = $clog2(FIFO_DEPTH + 1)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [0:0]        cfg_addr,
    input  logic [0:0]        cfg_wdata,
    input  logic              push,
    output logic              full,
    input  logic [2:0]        opcode,
    input  logic [6:0]        report_len,
    input  logic [7:0]        modifier_bits,
    input  logic [7:0]        key_slot0,
    input  logic [7:0]        key_slot1,
    input  logic [7:0]        key_slot2,
    input  logic [7:0]        key_slot3,
    input  logic [7:0]        key_slot4,
    input  logic [7:0]        key_slot5,
    output logic              empty,
    input  logic              pop,
    output logic [2:0]        event_kind,
    output logic [7:0]        event_key,
    output logic [7:0]        event_modifiers,
    output logic [6:0]        char_code,
    output logic [CNT_W-1:0]  queued_chars,
    output logic              caps_state,
    output logic              last_event
);

    logic             layout_jis_reg, clear_unmt_reg;
    logic             cmd_valid, cmd_pop;
    hidkbd_pkg::cmd_t cmd;
    hidkbd_pkg::res_t res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            layout_jis_reg <= 1'b0;
            clear_unmt_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                hidkbd_pkg::REG_LAYOUT_JIS: layout_jis_reg <= cfg_wdata[0];
                hidkbd_pkg::REG_CLEAR_UNMT: clear_unmt_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    hidkbd_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .opcode        (opcode),
        .report_len    (report_len),
        .modifier_bits (modifier_bits),
        .keys_in       ({key_slot5, key_slot4, key_slot3, key_slot2, key_slot1, key_slot0}),
        .cmd_valid     (cmd_valid),
        .cmd_out       (cmd),
        .cmd_pop       (cmd_pop)
    );

    hidkbd_back #(.FIFO_DEPTH(FIFO_DEPTH)) u_back
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .layout_jis       (layout_jis_reg),
        .clear_on_unmount (clear_unmt_reg),
        .cmd_valid        (cmd_valid),
        .cmd_in           (cmd),
        .cmd_pop          (cmd_pop),
        .empty            (empty),
        .pop              (pop),
        .res_out          (res),
        .res_queued       (queued_chars)
    );

    assign event_kind      = res.kind;
    assign event_key       = res.key;
    assign event_modifiers = res.mods;
    assign char_code       = res.ch;
    assign caps_state      = res.caps;
    assign last_event      = res.last;

    a_queued_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> queued_chars <= CNT_W'(FIFO_DEPTH))
        else $error("character count beyond depth");

    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (event_kind == hidkbd_pkg::EV_CHAR || event_kind == hidkbd_pkg::EV_EMPTY
                    || event_kind == hidkbd_pkg::EV_NONE)) |-> last_event)
        else $error("single-result request not marked last");

    a_key_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && event_kind == hidkbd_pkg::EV_CHAR) |-> (event_key == 8'h00
                                                          && event_modifiers == 8'h00))
        else $error("popped character carries key fields");

endmodule

// ===== verif/tb_hid_boot_keyboard_event_decoder.sv =====
`timescale 1ns / 1ps

module tb_hid_boot_keyboard_event_decoder;

    localparam int          CYCLE_LIMIT = 400000;
    localparam int          CHAR_DEPTH  = 16;
    localparam logic [2:0]  OP_SPARE    = 3'd7;
    localparam logic [6:0]  LEN_FULL    = 7'd8;
    localparam logic [7:0]  KEY_ZERO    = 8'h27;

    typedef struct {
        logic [2:0] kind;
        logic [7:0] key;
        logic [7:0] mods;
        logic [6:0] ch;
        logic [4:0] queued;
        logic       caps;
        logic       last;
    } event_t;

    class keyboard_scoreboard;
        bit             jis;
        bit             clear_unmount;
        bit [7:0]       prev_mods;
        bit [5:0][7:0]  held_keys;
        bit             prev_valid;
        bit             caps;
        bit [6:0]       chars [CHAR_DEPTH];
        int             wr_idx;
        int             rd_idx;
        int             count;
        int             errors;
        event_t         pending [$];
        event_t         batch [$];

        function new();
            jis           = 0;
            clear_unmount = 1;
            prev_mods     = '0;
            held_keys     = '0;
            prev_valid    = 0;
            caps          = 0;
            wr_idx        = 0;
            rd_idx        = 0;
            count         = 0;
            errors        = 0;
        endfunction

        function void add_event(logic [2:0] kind, logic [7:0] key, logic [7:0] mods,
                                logic [6:0] ch);
            event_t e;
            if (batch.size() >= 20)
                return;
            e.kind   = kind;
            e.key    = key;
            e.mods   = mods;
            e.ch     = ch;
            e.queued = '0;
            e.caps   = 0;
            e.last   = 0;
            batch.push_back(e);
        endfunction

        function void flush_chars();
            wr_idx = 0;
            rd_idx = 0;
            count  = 0;
        endfunction

        function bit [6:0] key_char(bit [7:0] key, bit [7:0] mods);
            bit sh;
            bit [7:0] off;
            sh = (mods & hidkbd_pkg::SHIFT_MASK) != 0;
            if (key == hidkbd_pkg::KEY_ENTER)
                return 7'h0A;
            if (key == hidkbd_pkg::KEY_BKSP)
                return 7'h08;
            if (key == hidkbd_pkg::KEY_TAB)
                return 7'h09;
            if (key >= hidkbd_pkg::LETTER_FIRST && key <= hidkbd_pkg::LETTER_LAST)
            begin
                off = key - hidkbd_pkg::LETTER_FIRST;
                return ((sh ^ caps) ? 7'h41 : 7'h61) + off[6:0];
            end
            if (key >= hidkbd_pkg::SYM_FIRST && key <= hidkbd_pkg::SYM_LAST)
            begin
                off = key - hidkbd_pkg::SYM_FIRST;
                return hidkbd_pkg::SYM_MAP[{jis, sh}][off[4:0]];
            end
            return 7'h00;
        endfunction

        function void press_key(bit [7:0] key, bit [7:0] mods);
            bit [6:0] c;
            if (key == hidkbd_pkg::KEY_CAPS)
            begin
                caps = ~caps;
                return;
            end
            c = key_char(key, mods);
            if (c != 0 && count < CHAR_DEPTH)
            begin
                chars[wr_idx] = c;
                wr_idx = (wr_idx + 1) % CHAR_DEPTH;
                count++;
            end
        endfunction

        function bit holds_key(bit [5:0][7:0] keys, bit [7:0] key);
            if (key == 0)
                return 0;
            for (int i = 0; i < 6; i++)
                if (keys[i] == key)
                    return 1;
            return 0;
        endfunction

        function void decode_report(bit [7:0] mods, bit [5:0][7:0] keys);
            bit [7:0] changed;
            changed = prev_valid ? (prev_mods ^ mods) : mods;
            for (int i = 0; i < 8; i++)
                if (changed[i])
                    add_event(mods[i] ? hidkbd_pkg::EV_DOWN : hidkbd_pkg::EV_UP,
                              8'h00, mods, 7'h00);
            for (int i = 0; i < 6; i++)
                if (keys[i] != 0 && !(prev_valid && holds_key(held_keys, keys[i])))
                begin
                    add_event(hidkbd_pkg::EV_DOWN, keys[i], mods, 7'h00);
                    press_key(keys[i], mods);
                end
            if (prev_valid)
                for (int i = 0; i < 6; i++)
                    if (held_keys[i] != 0 && !holds_key(keys, held_keys[i]))
                        add_event(hidkbd_pkg::EV_UP, held_keys[i], mods, 7'h00);
            prev_mods  = mods;
            held_keys  = keys;
            prev_valid = 1;
        endfunction

        function void note_request(logic [2:0] op, logic [6:0] len, logic [7:0] mods,
                                   logic [5:0][7:0] keys);
            batch.delete();
            case (op)
                hidkbd_pkg::OP_REPORT:
                    if (len >= hidkbd_pkg::MIN_REPORT)
                        decode_report(mods, keys);
                hidkbd_pkg::OP_POP:
                    if (count == 0)
                        add_event(hidkbd_pkg::EV_EMPTY, 8'h00, 8'h00, 7'h00);
                    else
                    begin
                        add_event(hidkbd_pkg::EV_CHAR, 8'h00, 8'h00, chars[rd_idx]);
                        rd_idx = (rd_idx + 1) % CHAR_DEPTH;
                        count--;
                    end
                hidkbd_pkg::OP_FLUSH:
                    flush_chars();
                hidkbd_pkg::OP_MOUNT:
                    prev_valid = 0;
                hidkbd_pkg::OP_UNMOUNT:
                begin
                    if (clear_unmount)
                    begin
                        flush_chars();
                        caps = 0;
                    end
                    prev_mods  = '0;
                    held_keys  = '0;
                    prev_valid = 0;
                end
                default: ;
            endcase
            if (batch.size() == 0)
                add_event(hidkbd_pkg::EV_NONE, 8'h00, 8'h00, 7'h00);
            foreach (batch[k])
            begin
                batch[k].queued = 5'(count);
                batch[k].caps   = caps;
                batch[k].last   = (k == batch.size() - 1);
                pending.push_back(batch[k]);
            end
        endfunction

        function void check_result(event_t got);
            event_t want;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result kind=%0d key=%h", got.kind, got.key);
                return;
            end
            want = pending.pop_front();
            if (got.kind !== want.kind || got.key !== want.key || got.mods !== want.mods ||
                got.ch !== want.ch || got.queued !== want.queued ||
                got.caps !== want.caps || got.last !== want.last)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("mismatch: expected kind=%0d key=%h mods=%h ch=%h q=%0d caps=%b last=%b",
                             want.kind, want.key, want.mods, want.ch, want.queued,
                             want.caps, want.last);
                    $display("          got      kind=%0d key=%h mods=%h ch=%h q=%0d caps=%b last=%b",
                             got.kind, got.key, got.mods, got.ch, got.queued,
                             got.caps, got.last);
                end
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [0:0]  cfg_addr;
    logic [0:0]  cfg_wdata;
    logic        push;
    logic        full;
    logic [2:0]  opcode;
    logic [6:0]  report_len;
    logic [7:0]  modifier_bits;
    logic [7:0]  key_slot0, key_slot1, key_slot2, key_slot3, key_slot4, key_slot5;
    logic        empty;
    logic        pop;
    logic [2:0]  event_kind;
    logic [7:0]  event_key;
    logic [7:0]  event_modifiers;
    logic [6:0]  char_code;
    logic [4:0]  queued_chars;
    logic        caps_state;
    logic        last_event;

    keyboard_scoreboard sb;
    int              send_idle;
    int              recv_idle;
    int              hold_left;
    int              cycles;
    bit [7:0]        cur_mods;
    bit [5:0][7:0]   cur_keys;

    hid_boot_keyboard_event_decoder dut (.*);

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // result side: sample pre-edge values, then decide next pop
    always @(posedge clk)
    begin
        event_t got;
        if (rst_n && pop && !empty)
        begin
            got.kind   = event_kind;
            got.key    = event_key;
            got.mods   = event_modifiers;
            got.ch     = char_code;
            got.queued = queued_chars;
            got.caps   = caps_state;
            got.last   = last_event;
            sb.check_result(got);
        end
        if (hold_left > 0)
        begin
            hold_left--;
            pop <= 1'b0;
        end
        else
            pop <= ($urandom_range(0, 99) >= recv_idle);
    end

    task automatic send_request(logic [2:0] op, logic [6:0] len, logic [7:0] mods,
                                logic [5:0][7:0] keys);
        if ($urandom_range(0, 99) < send_idle)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        push          <= 1'b1;
        opcode        <= op;
        report_len    <= len;
        modifier_bits <= mods;
        key_slot0     <= keys[0];
        key_slot1     <= keys[1];
        key_slot2     <= keys[2];
        key_slot3     <= keys[3];
        key_slot4     <= keys[4];
        key_slot5     <= keys[5];
        forever
        begin
            @(posedge clk);
            if (!full)
                break;
        end
        sb.note_request(op, len, mods, keys);
    endtask

    task automatic send_report(logic [7:0] mods, logic [5:0][7:0] keys);
        send_request(hidkbd_pkg::OP_REPORT, LEN_FULL, mods, keys);
    endtask

    task automatic send_op(logic [2:0] op);
        send_request(op, 7'($urandom_range(0, 127)), 8'($urandom), 48'({$urandom, $urandom}));
    endtask

    task automatic drain();
        push <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [0:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
        if (idx == hidkbd_pkg::REG_LAYOUT_JIS)
            sb.jis = val;
        else
            sb.clear_unmount = val;
    endtask

    function automatic bit [7:0] pick_key();
        case ($urandom_range(0, 9))
            0, 1:    return 8'h00;
            2, 3, 4: return 8'($urandom_range(hidkbd_pkg::LETTER_FIRST,
                                              hidkbd_pkg::LETTER_LAST));
            5, 6:    return 8'($urandom_range(hidkbd_pkg::SYM_FIRST, hidkbd_pkg::SYM_LAST));
            7:       return ($urandom_range(0, 3) == 0) ? hidkbd_pkg::KEY_CAPS
                                                        : hidkbd_pkg::KEY_ENTER;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic random_requests(int n);
        int sel;
        for (int i = 0; i < n; i++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 62)
            begin
                // evolve the held keys so up and down events mix
                for (int s = 0; s < 6; s++)
                    if ($urandom_range(0, 1))
                        cur_keys[s] = pick_key();
                if ($urandom_range(0, 2) == 0)
                    cur_mods = cur_mods ^ (8'h01 << $urandom_range(0, 7));
                else if ($urandom_range(0, 5) == 0)
                    cur_mods = 8'($urandom);
                sel = $urandom_range(0, 9);
                send_request(hidkbd_pkg::OP_REPORT,
                             (sel == 0) ? 7'($urandom_range(0, 7)) :
                             (sel == 1) ? 7'($urandom_range(65, 127)) :
                                          7'($urandom_range(8, 64)),
                             cur_mods, cur_keys);
            end
            else if (sel < 86)
                send_op(hidkbd_pkg::OP_POP);
            else if (sel < 90)
                send_op(hidkbd_pkg::OP_FLUSH);
            else if (sel < 94)
                send_op(hidkbd_pkg::OP_MOUNT);
            else if (sel < 97)
                send_op(hidkbd_pkg::OP_UNMOUNT);
            else
                send_op(3'($urandom_range(hidkbd_pkg::OP_IGNORE, OP_SPARE)));
        end
    endtask

    initial
    begin
        sb            = new();
        cycles        = 0;
        hold_left     = 0;
        send_idle     = 11;
        recv_idle     = 51;
        cur_mods      = '0;
        cur_keys      = '0;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_addr      = '0;
        cfg_wdata     = '0;
        push          = 1'b0;
        pop           = 1'b0;
        opcode        = '0;
        report_len    = '0;
        modifier_bits = '0;
        {key_slot0, key_slot1, key_slot2, key_slot3, key_slot4, key_slot5} = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_reg(hidkbd_pkg::REG_LAYOUT_JIS, 1'b0);
        write_reg(hidkbd_pkg::REG_CLEAR_UNMT, 1'b1);

        // directed: first report, all modifiers, repeated slot, overflow, pops
        send_op(hidkbd_pkg::OP_POP);
        send_report(8'hFF, {8'h04, 8'h04, 8'h1E, 8'h38, 8'h28, 8'h2A});
        send_report(8'h00, {8'h2B, 8'h2C, 8'h05, 8'h1D, 8'h2D, 8'hFF});
        send_report(8'h02, {8'h06, 8'h07, 8'h08, 8'h09, 8'h1F, 8'h34});
        send_report(8'h20, 48'h0);
        send_report(8'h00, {8'h39, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h0E});
        repeat (4) send_op(hidkbd_pkg::OP_POP);
        send_request(hidkbd_pkg::OP_REPORT, 7'd7, 8'hAA, {6{8'h11}});
        send_request(hidkbd_pkg::OP_REPORT, 7'd127, 8'h55, {6{8'h12}});
        send_op(hidkbd_pkg::OP_MOUNT);
        send_report(8'h55, {6{8'h12}});
        send_op(hidkbd_pkg::OP_FLUSH);
        send_op(hidkbd_pkg::OP_POP);
        send_op(OP_SPARE);
        send_op(hidkbd_pkg::OP_UNMOUNT);
        send_report(8'h00, {8'h39, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
        send_op(hidkbd_pkg::OP_POP);

        random_requests(45);
        drain();

        write_reg(hidkbd_pkg::REG_LAYOUT_JIS, 1'b1);
        write_reg(hidkbd_pkg::REG_CLEAR_UNMT, 1'b0);
        send_idle = 51;
        recv_idle = 11;
        // JIS shifted zero maps to nothing
        send_report(8'h02, {KEY_ZERO, 8'h1F, 8'h2E, 8'h00, 8'h00, 8'h00});
        send_report(8'h00, {KEY_ZERO, 8'h1F, 8'h2E, 8'h39, 8'h00, 8'h00});
        send_op(hidkbd_pkg::OP_UNMOUNT);
        send_op(hidkbd_pkg::OP_POP);
        random_requests(20);

        // hold results back so the block backs up into its input
        hold_left = 400;
        send_idle = 0;
        random_requests(20);
        send_idle = 51;
        drain();
        random_requests(15);
        drain();

        write_reg(hidkbd_pkg::REG_CLEAR_UNMT, 1'b1);
        send_idle = 0;
        recv_idle = 0;
        random_requests(45);
        drain();

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/hidkbd_pkg.sv
rtl/hidkbd_front.sv
rtl/hidkbd_back.sv
rtl/hid_boot_keyboard_event_decoder.sv
verif/tb_hid_boot_keyboard_event_decoder.sv
